### rtl/cau_pkg.sv
`timescale 1ns / 1ps
// cau_pkg: shared types, widths and helpers for the complex arithmetic unit.
// No dependencies.
package cau_pkg;

    localparam int DATA_W = 16;
    localparam int FRAC_W = 8;
    localparam int PROD_W = 2 * DATA_W;
    localparam int NUM_W  = PROD_W + FRAC_W;
    localparam int QUOT_W = DATA_W + 1;
    localparam int LAT    = DATA_W + 4;

    typedef enum logic [1:0] {
        OP_ADD = 2'd0,
        OP_SUB = 2'd1,
        OP_MUL = 2'd2,
        OP_DIV = 2'd3
    } op_t;

    typedef struct packed {
        op_t                      req_type;
        logic signed [DATA_W-1:0] a_re;
        logic signed [DATA_W-1:0] a_im;
        logic signed [DATA_W-1:0] b_re;
        logic signed [DATA_W-1:0] b_im;
    } req_t;

    typedef struct packed {
        logic signed [DATA_W-1:0] res_re;
        logic signed [DATA_W-1:0] res_im;
        logic                     div_zero;
        logic                     overflow;
    } res_t;

    // one result part on its way through the divider chain
    typedef struct packed {
        logic [PROD_W-1:0] rem;
        logic [DATA_W-1:0] nlow;
        logic [QUOT_W-1:0] quot;
        logic              big;
        logic              neg;
    } lane_t;

    typedef struct packed {
        logic              valid;
        logic              div;
        logic              dz;
        logic [PROD_W-1:0] den;
        lane_t             re;
        lane_t             im;
    } stage_t;

    function automatic logic signed [PROD_W:0] sx(input logic signed [DATA_W-1:0] v);
        sx = {{(PROD_W + 1 - DATA_W){v[DATA_W-1]}}, v};
    endfunction

    function automatic logic signed [PROD_W:0] px(input logic signed [PROD_W-1:0] v);
        px = {v[PROD_W-1], v};
    endfunction

endpackage

### rtl/cau_div_cell.sv
`timescale 1ns / 1ps
// cau_div_cell: one restoring-division step for both result parts, registered.
// Depends on cau_pkg.
module cau_div_cell
    import cau_pkg::*;
(
    input  logic   clk,
    input  logic   rst_n,
    input  stage_t din,
    output stage_t dout
);

    stage_t stage_reg;
    stage_t stage_next;

    function automatic lane_t step(input lane_t l, input logic [PROD_W-1:0] den);
        logic [PROD_W:0] t;
        logic            ge;
        lane_t           r;
        t      = {l.rem, l.nlow[DATA_W-1]};
        ge     = t >= {1'b0, den};
        r      = l;
        r.rem  = ge ? PROD_W'(t - {1'b0, den}) : PROD_W'(t);
        r.nlow = {l.nlow[DATA_W-2:0], 1'b0};
        r.quot = {l.quot[QUOT_W-2:0], ge};
        step   = r;
    endfunction

    always_comb
    begin
        stage_next = din;
        if (din.div)
        begin
            stage_next.re = step(din.re, din.den);
            stage_next.im = step(din.im, din.den);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stage_reg <= '0;
        end
        else
        begin
            stage_reg <= stage_next;
        end
    end

    assign dout = stage_reg;

endmodule

### rtl/cau_prep.sv
`timescale 1ns / 1ps
// cau_prep: product stage and operand preparation feeding the divider chain.
// Depends on cau_pkg.
module cau_prep
    import cau_pkg::*;
(
    input  logic   clk,
    input  logic   rst_n,
    input  logic   valid,
    input  req_t   req,
    output stage_t dout
);

    logic                     valid_reg;
    op_t                      op_reg;
    logic signed [DATA_W-1:0] a_reg, b_reg, c_reg, d_reg;
    logic signed [PROD_W-1:0] ac_reg, bd_reg, bc_reg, ad_reg, cc_reg, dd_reg;

    logic signed [PROD_W:0]   s_re, s_im;
    logic [PROD_W-1:0]        den;
    logic                     dz;
    stage_t                   stage_reg;
    stage_t                   stage_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            stage_reg <= '0;
        end
        else
        begin
            valid_reg <= valid;
            stage_reg <= stage_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg <= req.req_type;
        a_reg  <= req.a_re;
        b_reg  <= req.a_im;
        c_reg  <= req.b_re;
        d_reg  <= req.b_im;
        ac_reg <= req.a_re * req.b_re;
        bd_reg <= req.a_im * req.b_im;
        bc_reg <= req.a_im * req.b_re;
        ad_reg <= req.a_re * req.b_im;
        cc_reg <= req.b_re * req.b_re;
        dd_reg <= req.b_im * req.b_im;
    end

    function automatic lane_t make_lane(input logic signed [PROD_W:0] s, input op_t op,
                                        input logic [PROD_W-1:0] d);
        logic [PROD_W:0]   m;
        logic [PROD_W-1:0] mag;
        logic [PROD_W-1:0] sh;
        logic [NUM_W-1:0]  n;
        logic [NUM_W-1:0]  r0;
        lane_t             l;
        m      = s[PROD_W] ? (PROD_W + 1)'(-s) : s;
        mag    = m[PROD_W-1:0];
        sh     = mag >> FRAC_W;
        n      = {mag, {FRAC_W{1'b0}}};
        r0     = n >> DATA_W;
        l.neg  = s[PROD_W];
        l.rem  = '0;
        l.nlow = '0;
        l.quot = '0;
        l.big  = 1'b0;
        unique case (op)
            OP_ADD, OP_SUB:
            begin
                l.quot = mag[QUOT_W-1:0];
                l.big  = |mag[PROD_W-1:QUOT_W];
            end
            OP_MUL:
            begin
                l.quot = sh[QUOT_W-1:0];
                l.big  = |sh[PROD_W-1:QUOT_W];
            end
            OP_DIV:
            begin
                l.big  = r0 >= NUM_W'(d);
                l.rem  = l.big ? '0 : PROD_W'(r0);
                l.nlow = n[DATA_W-1:0];
            end
            default:
            begin
                l.quot = '0;
            end
        endcase
        make_lane = l;
    endfunction

    always_comb
    begin
        s_re = '0;
        s_im = '0;
        unique case (op_reg)
            OP_ADD:
            begin
                s_re = sx(a_reg) + sx(c_reg);
                s_im = sx(b_reg) + sx(d_reg);
            end
            OP_SUB:
            begin
                s_re = sx(a_reg) - sx(c_reg);
                s_im = sx(b_reg) - sx(d_reg);
            end
            OP_MUL:
            begin
                s_re = px(ac_reg) - px(bd_reg);
                s_im = px(bc_reg) + px(ad_reg);
            end
            OP_DIV:
            begin
                s_re = px(ac_reg) + px(bd_reg);
                s_im = px(bc_reg) - px(ad_reg);
            end
            default:
            begin
                s_re = '0;
            end
        endcase
    end

    assign den = $unsigned(cc_reg) + $unsigned(dd_reg);
    assign dz  = (op_reg == OP_DIV) && (c_reg == '0) && (d_reg == '0);

    always_comb
    begin
        stage_next.valid = valid_reg;
        stage_next.dz    = dz;
        stage_next.div   = (op_reg == OP_DIV) && !dz;
        stage_next.den   = den;
        stage_next.re    = make_lane(s_re, op_reg, den);
        stage_next.im    = make_lane(s_im, op_reg, den);
        if (dz)
        begin
            stage_next.re = '0;
            stage_next.im = '0;
        end
    end

    assign dout = stage_reg;

endmodule

### rtl/complex_arith_unit_top.sv
`timescale 1ns / 1ps
// complex_arith_unit_top: complex add/sub/mul/div ALU in signed Q7.8.
// Depends on cau_pkg, cau_prep, cau_div_cell.
//
// Usage:
//   A transaction enters when start is high and busy is low; req holds the
//   opcode and both complex operands. Each transaction gives one result on
//   res, marked by done for exactly one cycle.
//   Throughput is one transaction per cycle for every opcode: the divide runs
//   through a chain of DATA_W cells, each producing one quotient bit for both
//   result parts, and the other opcodes ride the same chain unchanged.
//   The latency is set by the chain length plus input, product, preparation
//   and output registers.
//   Reset clears all valid flags; busy is high during reset and until the first
//   clock edge after it, then stays low.
//   The receiver cannot stall: results are presented once and must be taken.
//   Overflowing parts saturate and set overflow; a zero divisor gives zero
//   parts with div_zero set.
module complex_arith_unit_top
    import cau_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic start,
    output logic busy,
    input  req_t req,
    output logic done,
    output res_t res
);

    logic   busy_reg;
    logic   in_valid_reg;
    req_t   in_req_reg;
    logic   done_reg;
    res_t   res_reg;
    res_t   res_next;
    stage_t chain [DATA_W+1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg     <= 1'b1;
            in_valid_reg <= 1'b0;
            done_reg     <= 1'b0;
        end
        else
        begin
            busy_reg     <= 1'b0;
            in_valid_reg <= start && !busy_reg;
            done_reg     <= chain[DATA_W].valid;
        end
    end

    always_ff @(posedge clk)
    begin
        in_req_reg <= req;
        res_reg    <= res_next;
    end

    cau_prep u_prep (
        .clk   (clk),
        .rst_n (rst_n),
        .valid (in_valid_reg),
        .req   (in_req_reg),
        .dout  (chain[0])
    );

    for (genvar i = 0; i < DATA_W; i++)
    begin : g_cell
        cau_div_cell u_cell (
            .clk   (clk),
            .rst_n (rst_n),
            .din   (chain[i]),
            .dout  (chain[i+1])
        );
    end

    function automatic logic [DATA_W:0] sat(input lane_t l);
        logic [QUOT_W-1:0] lim;
        logic [QUOT_W-1:0] mag;
        logic              hit;
        logic [QUOT_W-1:0] v;
        lim = l.neg ? QUOT_W'(1) << (DATA_W - 1) : (QUOT_W'(1) << (DATA_W - 1)) - 1'b1;
        hit = l.big || (l.quot > lim);
        mag = hit ? lim : l.quot;
        v   = l.neg ? QUOT_W'(-mag) : mag;
        sat = {hit, v[DATA_W-1:0]};
    endfunction

    logic [DATA_W:0] sat_re, sat_im;

    assign sat_re = sat(chain[DATA_W].re);
    assign sat_im = sat(chain[DATA_W].im);

    always_comb
    begin
        res_next.res_re   = sat_re[DATA_W-1:0];
        res_next.res_im   = sat_im[DATA_W-1:0];
        res_next.div_zero = chain[DATA_W].dz;
        res_next.overflow = sat_re[DATA_W] | sat_im[DATA_W];
    end

    assign busy = busy_reg;
    assign done = done_reg;
    assign res  = res_reg;

    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(start && !busy, LAT))
        else $error("result without matching transaction");

    a_dz_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (done && res.div_zero) |-> (res.res_re == '0 && res.res_im == '0 && !res.overflow))
        else $error("zero divisor result not cleared");

    a_ovf_limit: assert property (@(posedge clk) disable iff (!rst_n)
        (done && res.overflow) |->
            (res.res_re == {1'b0, {(DATA_W-1){1'b1}}} || res.res_re == {1'b1, {(DATA_W-1){1'b0}}}
          || res.res_im == {1'b0, {(DATA_W-1){1'b1}}} || res.res_im == {1'b1, {(DATA_W-1){1'b0}}}))
        else $error("overflow without saturated part");

    a_busy_low: assert property (@(posedge clk) disable iff (!rst_n)
        !busy |=> !busy)
        else $error("busy rose after reset");

endmodule

### tb/complex_arith_unit_checker.sv
`timescale 1ns / 1ps
// complex_arith_unit_checker: predicts and checks every complex ALU transaction.
// Depends on cau_pkg; watches start/busy/req and done/res of the block.
module complex_arith_unit_checker
    import cau_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic start,
    input  logic busy,
    input  req_t req,
    input  logic done,
    input  res_t res,
    output int   fail_count,
    output int   pending
);

    res_t expected_q[$];

    function automatic logic [DATA_W-1:0] clamp_part(input logic signed [63:0] v,
                                                      inout logic ovf);
        logic signed [63:0] hi;
        logic signed [63:0] lo;
        hi = (64'sd1 <<< (DATA_W - 1)) - 1;
        lo = -(64'sd1 <<< (DATA_W - 1));
        if (v > hi)
        begin
            ovf = 1'b1;
            return hi[DATA_W-1:0];
        end
        if (v < lo)
        begin
            ovf = 1'b1;
            return lo[DATA_W-1:0];
        end
        return v[DATA_W-1:0];
    endfunction

    // truncation toward zero of n * 2^FRAC / d, magnitude capped
    function automatic logic signed [63:0] trunc_div(input logic signed [63:0] n,
                                                      input logic signed [63:0] d);
        logic [63:0] mag;
        logic [63:0] q;
        logic        neg;
        neg = n < 0;
        mag = neg ? -n : n;
        q = (mag << FRAC_W) / d;
        if (q > (64'd1 << DATA_W))
            q = 64'd1 << DATA_W;
        return neg ? -$signed(q) : $signed(q);
    endfunction

    function automatic logic signed [63:0] trunc_shift(input logic signed [63:0] v);
        logic [63:0] mag;
        mag = (v < 0) ? -v : v;
        mag = mag >> FRAC_W;
        return (v < 0) ? -$signed(mag) : $signed(mag);
    endfunction

    function automatic res_t predict_complex(input req_t r);
        res_t o;
        logic signed [63:0] a, b, c, d, re, im, den;
        logic ovf;
        a = r.a_re; b = r.a_im; c = r.b_re; d = r.b_im;
        ovf = 1'b0;
        o = '0;
        case (r.req_type)
            OP_ADD:
            begin
                re = a + c; im = b + d;
            end
            OP_SUB:
            begin
                re = a - c; im = b - d;
            end
            OP_MUL:
            begin
                re = trunc_shift(a * c - b * d);
                im = trunc_shift(b * c + a * d);
            end
            default:
            begin
                if (c == 0 && d == 0)
                begin
                    o.div_zero = 1'b1;
                    return o;
                end
                den = c * c + d * d;
                re = trunc_div(a * c + b * d, den);
                im = trunc_div(b * c - a * d, den);
            end
        endcase
        o.res_re = clamp_part(re, ovf);
        o.res_im = clamp_part(im, ovf);
        o.overflow = ovf;
        return o;
    endfunction

    assign pending = expected_q.size();

    always @(posedge clk or negedge rst_n)
    begin
        res_t e;
        if (!rst_n)
        begin
            fail_count <= 0;
            expected_q.delete();
        end
        else
        begin
            if (done)
            begin
                if (expected_q.size() == 0)
                begin
                    $display("%0t: unexpected result %h", $time, res);
                    fail_count <= fail_count + 1;
                end
                else
                begin
                    e = expected_q.pop_front();
                    if (e !== res)
                    begin
                        $display("%0t: mismatch expected re=%h im=%h dz=%b ov=%b",
                                 $time, e.res_re, e.res_im, e.div_zero, e.overflow);
                        $display("%0t:          actual   re=%h im=%h dz=%b ov=%b",
                                 $time, res.res_re, res.res_im, res.div_zero,
                                 res.overflow);
                        fail_count <= fail_count + 1;
                    end
                end
            end
            if (start && !busy)
                expected_q.push_back(predict_complex(req));
        end
    end

endmodule

### tb/complex_arith_unit_top_tb.sv
`timescale 1ns / 1ps
// complex_arith_unit_top_tb: directed and random stimulus for the complex ALU.
// Depends on cau_pkg, complex_arith_unit_top and complex_arith_unit_checker.
module complex_arith_unit_top_tb;
    import cau_pkg::*;

    logic clk;
    logic rst_n;
    logic start;
    logic busy;
    req_t req;
    logic done;
    res_t res;
    int   fail_count;
    int   pending;
    int   idle_cycles;
    req_t directed[$];

    localparam int WATCHDOG = 2000;

    complex_arith_unit_top dut (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
        .req(req), .done(done), .res(res)
    );

    complex_arith_unit_checker chk (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .req(req),
        .done(done), .res(res), .fail_count(fail_count), .pending(pending)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    always @(posedge clk)
    begin
        if ((start && !busy) || done)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG)
        begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    function automatic logic [DATA_W-1:0] pick_value();
        case ($urandom_range(0, 9))
            0: return 16'h7fff;
            1: return 16'h8000;
            2: return 16'h0000;
            3: return 16'(int'($urandom_range(0, 8)) - 4);
            4: return 16'h0100;
            5: return 16'hff00;
            6: return 16'($urandom_range(0, 1023));
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic req_t random_req();
        req_t r;
        r.req_type = op_t'($urandom_range(0, 3));
        r.a_re = pick_value();
        r.a_im = pick_value();
        r.b_re = pick_value();
        r.b_im = pick_value();
        if (r.req_type == OP_DIV && $urandom_range(0, 15) == 0)
        begin
            r.b_re = '0;
            r.b_im = '0;
        end
        return r;
    endfunction

    function automatic req_t mk(input op_t op, input logic [15:0] ar, input logic [15:0] ai,
                                input logic [15:0] br, input logic [15:0] bi);
        req_t r;
        r.req_type = op; r.a_re = ar; r.a_im = ai; r.b_re = br; r.b_im = bi;
        return r;
    endfunction

    task automatic send_transaction(input req_t r);
        start <= 1'b1;
        req   <= r;
        @(posedge clk);
        while (busy)
            @(posedge clk);
    endtask

    task automatic random_gap();
        int n;
        if ($urandom_range(0, 2) != 0)
            return;
        n = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40) : $urandom_range(1, 3);
        start <= 1'b0;
        repeat (n) @(posedge clk);
    endtask

    initial
    begin
        op_t op;
        idle_cycles = 0;
        rst_n = 1'b0;
        start = 1'b0;
        req   = '0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int i = 0; i < 4; i++)
        begin
            op = op_t'(i);
            directed.push_back(mk(op, 16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff));
            directed.push_back(mk(op, 16'h8000, 16'h8000, 16'h8000, 16'h8000));
            directed.push_back(mk(op, 16'h7fff, 16'h8000, 16'h8000, 16'h7fff));
            directed.push_back(mk(op, 16'h0100, 16'hff00, 16'h0100, 16'h0000));
            directed.push_back(mk(op, 16'hffff, 16'h0001, 16'h0003, 16'hfffd));
        end
        directed.push_back(mk(OP_DIV, 16'h1234, 16'h8000, 16'h0000, 16'h0000));
        directed.push_back(mk(OP_DIV, 16'h7fff, 16'h7fff, 16'h0001, 16'h0000));
        directed.push_back(mk(OP_DIV, 16'h8000, 16'h0000, 16'h0000, 16'h0001));
        directed.push_back(mk(OP_DIV, 16'h0000, 16'h0000, 16'h0000, 16'h0000));
        foreach (directed[i])
            send_transaction(directed[i]);

        start <= 1'b0;
        while (pending != 0)
            @(posedge clk);

        for (int i = 0; i < 500; i++)
        begin
            send_transaction(random_req());
            if (i == 250)
            begin
                start <= 1'b0;
                while (pending != 0)
                    @(posedge clk);
            end
            else if (i < 100 || i > 400)
                random_gap();
        end
        start <= 1'b0;

        while (pending != 0)
            @(posedge clk);
        repeat (LAT + 5) @(posedge clk);
        if (fail_count == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule

### filelist.f
rtl/cau_pkg.sv
rtl/cau_div_cell.sv
rtl/cau_prep.sv
rtl/complex_arith_unit_top.sv
tb/complex_arith_unit_checker.sv
tb/complex_arith_unit_top_tb.sv
